>>> rtl/core/ipac_pkg.sv
// package: character codes, limits and verdict codes for the address classifier
package ipac_pkg;

    // character codes
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_F   = 8'h46;

    // group and digit limits
    localparam logic [2:0] DOT_LAST_GROUP  = 3'd3;
    localparam logic [1:0] DOT_MAX_DIGITS  = 2'd3;
    localparam logic [8:0] DOT_MAX_VALUE   = 9'd255;
    localparam logic [3:0] HEX_LAST_GROUP  = 4'd7;
    localparam logic [2:0] HEX_MAX_DIGITS  = 3'd4;

    // kind of the most recent separator
    typedef enum logic [1:0] {
        SEP_NONE  = 2'd0,
        SEP_DOT   = 2'd1,
        SEP_COLON = 2'd2
    } sep_kind_t;

    // verdict codes
    typedef enum logic [1:0] {
        VERDICT_NEITHER = 2'd0,
        VERDICT_IPV4    = 2'd1,
        VERDICT_IPV6    = 2'd2
    } verdict_t;

endpackage

>>> rtl/core/ip_address_text_classifier_core.sv
// top level: streaming IPv4 / IPv6 address text classifier
//
// usage:
//   input channel (in_valid / in_ready): one character per request, char_code
//   holds the byte and last_char marks the final byte of the string
//   output channel (out_valid / out_ready): one verdict per string,
//   0 neither, 1 valid IPv4, 2 valid IPv6
//   throughput: one character per cycle while in_ready is high; the dotted
//   and hex checks update together from the checker state registers
//   the verdict sits in the output register from the cycle after the final
//   character is accepted
//   all checker state returns to its start values after the final character,
//   so the next string may follow in the very next cycle
//   reset clears the checker state and empties the output register
//   when the receiver stalls with a verdict pending, in_ready drops until the
//   verdict is taken; in_ready stays high in the cycle the verdict is taken
module ip_address_text_classifier_core
    import ipac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] verdict
);

    sep_kind_t   sep_kind_reg,  sep_kind_next;
    logic        dot_ok_reg,    dot_ok_next;
    logic [2:0]  dot_groups_reg, dot_groups_next;
    logic [1:0]  dot_digits_reg, dot_digits_next;
    logic [8:0]  dot_value_reg, dot_value_next;
    logic        dot_lzero_reg, dot_lzero_next;
    logic        hex_ok_reg,    hex_ok_next;
    logic [3:0]  hex_groups_reg, hex_groups_next;
    logic [2:0]  hex_digits_reg, hex_digits_next;
    logic        out_valid_reg, out_valid_next;
    verdict_t    verdict_reg,   verdict_next;

    logic        accept;
    logic        is_dec;
    logic        is_hex;
    logic        is_dot;
    logic        is_colon;
    logic [11:0] dot_value_calc;

    // verdict evaluated on the pre-clear values
    logic        fin_dot_ok;
    logic        fin_hex_ok;
    logic [2:0]  fin_dot_groups;
    logic [1:0]  fin_dot_digits;
    logic [3:0]  fin_hex_groups;
    logic [2:0]  fin_hex_digits;
    sep_kind_t   fin_sep;

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // character classes
    assign is_dec   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign is_hex   = is_dec
                   || ((char_code >= CHAR_LOW_A) && (char_code <= CHAR_LOW_F))
                   || ((char_code >= CHAR_UP_A) && (char_code <= CHAR_UP_F));
    assign is_dot   = (char_code == CHAR_DOT);
    assign is_colon = (char_code == CHAR_COLON);

    // running decimal group value
    assign dot_value_calc = ({3'd0, dot_value_reg} * 12'd10) + {8'd0, char_code[3:0]};

    // checker state update
    always_comb
    begin
        sep_kind_next   = sep_kind_reg;
        dot_ok_next     = dot_ok_reg;
        dot_groups_next = dot_groups_reg;
        dot_digits_next = dot_digits_reg;
        dot_value_next  = dot_value_reg;
        dot_lzero_next  = dot_lzero_reg;
        hex_ok_next     = hex_ok_reg;
        hex_groups_next = hex_groups_reg;
        hex_digits_next = hex_digits_reg;

        if (accept)
        begin
            // separator kind
            if (is_dot)
            begin
                sep_kind_next = SEP_DOT;
            end
            else if (is_colon)
            begin
                sep_kind_next = SEP_COLON;
            end

            // dotted checker
            if (is_dec)
            begin
                if ((dot_digits_reg >= DOT_MAX_DIGITS)
                    || ((dot_digits_reg != 2'd0) && dot_lzero_reg))
                begin
                    dot_ok_next = 1'b0;
                end
                if ((dot_digits_reg == 2'd0) && (char_code == CHAR_ZERO))
                begin
                    dot_lzero_next = 1'b1;
                end
                if (dot_value_calc > {3'd0, DOT_MAX_VALUE})
                begin
                    dot_ok_next    = 1'b0;
                    dot_value_next = DOT_MAX_VALUE + 9'd1;
                end
                else
                begin
                    dot_value_next = dot_value_calc[8:0];
                end
                if (dot_digits_reg < DOT_MAX_DIGITS)
                begin
                    dot_digits_next = dot_digits_reg + 2'd1;
                end
            end
            else if (is_dot)
            begin
                if ((dot_digits_reg == 2'd0) || (dot_groups_reg >= DOT_LAST_GROUP))
                begin
                    dot_ok_next = 1'b0;
                end
                else
                begin
                    dot_groups_next = dot_groups_reg + 3'd1;
                end
                dot_digits_next = 2'd0;
                dot_value_next  = 9'd0;
                dot_lzero_next  = 1'b0;
            end
            else
            begin
                dot_ok_next = 1'b0;
            end

            // hex checker
            if (is_hex)
            begin
                if (hex_digits_reg >= HEX_MAX_DIGITS)
                begin
                    hex_ok_next = 1'b0;
                end
                else
                begin
                    hex_digits_next = hex_digits_reg + 3'd1;
                end
            end
            else if (is_colon)
            begin
                if ((hex_digits_reg == 3'd0) || (hex_groups_reg >= HEX_LAST_GROUP))
                begin
                    hex_ok_next = 1'b0;
                end
                else
                begin
                    hex_groups_next = hex_groups_reg + 4'd1;
                end
                hex_digits_next = 3'd0;
            end
            else
            begin
                hex_ok_next = 1'b0;
            end

            // end of string: back to start values
            if (last_char)
            begin
                sep_kind_next   = SEP_NONE;
                dot_ok_next     = 1'b1;
                dot_groups_next = 3'd0;
                dot_digits_next = 2'd0;
                dot_value_next  = 9'd0;
                dot_lzero_next  = 1'b0;
                hex_ok_next     = 1'b1;
                hex_groups_next = 4'd0;
                hex_digits_next = 3'd0;
            end
        end
    end

    // checker view including the final character
    always_comb
    begin
        fin_sep        = sep_kind_reg;
        fin_dot_ok     = dot_ok_reg;
        fin_dot_groups = dot_groups_reg;
        fin_dot_digits = dot_digits_reg;
        fin_hex_ok     = hex_ok_reg;
        fin_hex_groups = hex_groups_reg;
        fin_hex_digits = hex_digits_reg;

        // separator kind
        if (is_dot)
        begin
            fin_sep = SEP_DOT;
        end
        else if (is_colon)
        begin
            fin_sep = SEP_COLON;
        end

        // dotted view of the final character
        if (is_dec)
        begin
            if ((dot_digits_reg >= DOT_MAX_DIGITS)
                || ((dot_digits_reg != 2'd0) && dot_lzero_reg)
                || (dot_value_calc > {3'd0, DOT_MAX_VALUE}))
            begin
                fin_dot_ok = 1'b0;
            end
            if (dot_digits_reg < DOT_MAX_DIGITS)
            begin
                fin_dot_digits = dot_digits_reg + 2'd1;
            end
        end
        else if (is_dot)
        begin
            if ((dot_digits_reg == 2'd0) || (dot_groups_reg >= DOT_LAST_GROUP))
            begin
                fin_dot_ok = 1'b0;
            end
            else
            begin
                fin_dot_groups = dot_groups_reg + 3'd1;
            end
            fin_dot_digits = 2'd0;
        end
        else
        begin
            fin_dot_ok = 1'b0;
        end

        // hex view of the final character
        if (is_hex)
        begin
            if (hex_digits_reg >= HEX_MAX_DIGITS)
            begin
                fin_hex_ok = 1'b0;
            end
            else
            begin
                fin_hex_digits = hex_digits_reg + 3'd1;
            end
        end
        else if (is_colon)
        begin
            if ((hex_digits_reg == 3'd0) || (hex_groups_reg >= HEX_LAST_GROUP))
            begin
                fin_hex_ok = 1'b0;
            end
            else
            begin
                fin_hex_groups = hex_groups_reg + 4'd1;
            end
            fin_hex_digits = 3'd0;
        end
        else
        begin
            fin_hex_ok = 1'b0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        verdict_next   = verdict_reg;
        if (accept && last_char)
        begin
            out_valid_next = 1'b1;
            if ((fin_sep == SEP_DOT) && fin_dot_ok && (fin_dot_digits != 2'd0)
                && (fin_dot_groups == DOT_LAST_GROUP))
            begin
                verdict_next = VERDICT_IPV4;
            end
            else if ((fin_sep == SEP_COLON) && fin_hex_ok && (fin_hex_digits != 3'd0)
                     && (fin_hex_groups == HEX_LAST_GROUP))
            begin
                verdict_next = VERDICT_IPV6;
            end
            else
            begin
                verdict_next = VERDICT_NEITHER;
            end
        end
    end

    // checker and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_kind_reg   <= SEP_NONE;
            dot_ok_reg     <= 1'b1;
            dot_groups_reg <= 3'd0;
            dot_digits_reg <= 2'd0;
            dot_value_reg  <= 9'd0;
            dot_lzero_reg  <= 1'b0;
            hex_ok_reg     <= 1'b1;
            hex_groups_reg <= 4'd0;
            hex_digits_reg <= 3'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            sep_kind_reg   <= sep_kind_next;
            dot_ok_reg     <= dot_ok_next;
            dot_groups_reg <= dot_groups_next;
            dot_digits_reg <= dot_digits_next;
            dot_value_reg  <= dot_value_next;
            dot_lzero_reg  <= dot_lzero_next;
            hex_ok_reg     <= hex_ok_next;
            hex_groups_reg <= hex_groups_next;
            hex_digits_reg <= hex_digits_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // verdict payload
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

>>> bench/ip_address_text_classifier_core_tb.sv
// testbench for the streaming IPv4 / IPv6 address text classifier
`timescale 1ns / 100ps

module ip_address_text_classifier_core_tb;
    import ipac_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CHARS   = 330;
    localparam int LONG_HOLD      = 64;

    typedef logic [7:0] text_t[$];

    // scanner state kept by the predictor
    typedef struct {
        sep_kind_t  sep;
        logic       dot_ok;
        logic [2:0] dot_groups;
        logic [1:0] dot_digits;
        logic [8:0] dot_value;
        logic       dot_lead0;
        logic       hex_ok;
        logic [3:0] hex_groups;
        logic [2:0] hex_digits;
    } scan_state_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_code;
    logic       last_char;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] verdict;

    scan_state_t scan;
    verdict_t    expected_verdicts[$];
    int          fail_count;
    int          chars_sent;
    int          quiet_cycles;
    logic        tx_idle_on;
    logic        rx_idle_on;
    logic        hold_req;

    ip_address_text_classifier_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .verdict   (verdict)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // failure log, only the first ten are printed
    function automatic void log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void clear_scan();
        scan.sep        = SEP_NONE;
        scan.dot_ok     = 1'b1;
        scan.dot_groups = '0;
        scan.dot_digits = '0;
        scan.dot_value  = '0;
        scan.dot_lead0  = 1'b0;
        scan.hex_ok     = 1'b1;
        scan.hex_groups = '0;
        scan.hex_digits = '0;
    endfunction

    // predictor: advance the scanner by one character, returns 1 when a verdict is due
    function automatic logic classify_char(input logic [7:0] c, input logic l,
                                           output verdict_t v);
        int   value;
        logic is_dec;
        logic is_hex;
        logic v4;
        logic v6;
        is_dec = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        is_hex = is_dec || (c >= CHAR_LOW_A && c <= CHAR_LOW_F)
                        || (c >= CHAR_UP_A && c <= CHAR_UP_F);
        v = VERDICT_NEITHER;

        // remember the most recent separator
        if (c == CHAR_DOT)
            scan.sep = SEP_DOT;
        else if (c == CHAR_COLON)
            scan.sep = SEP_COLON;

        // dotted decimal rules
        if (is_dec)
        begin
            if (scan.dot_digits >= DOT_MAX_DIGITS || (scan.dot_digits != 0 && scan.dot_lead0))
                scan.dot_ok = 1'b0;
            if (scan.dot_digits == 0 && c == CHAR_ZERO)
                scan.dot_lead0 = 1'b1;
            value = int'(scan.dot_value) * 10 + int'(c - CHAR_ZERO);
            // saturate just above the group limit
            if (value > int'(DOT_MAX_VALUE))
            begin
                scan.dot_ok = 1'b0;
                value = int'(DOT_MAX_VALUE) + 1;
            end
            scan.dot_value = 9'(value);
            if (scan.dot_digits < DOT_MAX_DIGITS)
                scan.dot_digits++;
        end
        else if (c == CHAR_DOT)
        begin
            if (scan.dot_digits == 0 || scan.dot_groups >= DOT_LAST_GROUP)
                scan.dot_ok = 1'b0;
            else
                scan.dot_groups++;
            scan.dot_digits = '0;
            scan.dot_value  = '0;
            scan.dot_lead0  = 1'b0;
        end
        else
        begin
            scan.dot_ok = 1'b0;
        end

        // colon hex rules
        if (is_hex)
        begin
            if (scan.hex_digits >= HEX_MAX_DIGITS)
                scan.hex_ok = 1'b0;
            else
                scan.hex_digits++;
        end
        else if (c == CHAR_COLON)
        begin
            if (scan.hex_digits == 0 || scan.hex_groups >= HEX_LAST_GROUP)
                scan.hex_ok = 1'b0;
            else
                scan.hex_groups++;
            scan.hex_digits = '0;
        end
        else
        begin
            scan.hex_ok = 1'b0;
        end

        if (!l)
            return 1'b0;

        // final character: judge and start over
        v4 = scan.dot_ok && scan.dot_digits != 0 && scan.dot_groups == DOT_LAST_GROUP;
        v6 = scan.hex_ok && scan.hex_digits != 0 && scan.hex_groups == HEX_LAST_GROUP;
        if (scan.sep == SEP_DOT && v4)
            v = VERDICT_IPV4;
        else if (scan.sep == SEP_COLON && v6)
            v = VERDICT_IPV6;
        clear_scan();
        return 1'b1;
    endfunction

    // send one character request, with an optional random gap before it
    task automatic send_char(input logic [7:0] c, input logic l);
        verdict_t v;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid  = 1'b1;
        char_code = c;
        last_char = l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (classify_char(c, l, v))
            expected_verdicts.push_back(v);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_text(input text_t t);
        for (int i = 0; i < t.size(); i++)
            send_char(t[i], i == t.size() - 1);
    endtask

    // stop sending until every pending verdict has been taken
    task automatic wait_for_verdicts();
        in_valid  = 1'b0;
        last_char = 1'b0;
        while (expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // random address text: mostly well formed, some broken, some noise
    task automatic make_address(output text_t t);
        string s;
        string hex_chars;
        int    kind;
        int    groups;
        int    r;
        int    n;
        int    pos;
        hex_chars = "0123456789abcdefABCDEF";
        s = "";
        t = {};
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            // dotted decimal
            groups = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 4;
            for (int g = 0; g < groups; g++)
            begin
                r = $urandom_range(0, 11);
                if (g != 0)
                    s = {s, "."};
                if (r < 9)
                    s = {s, $sformatf("%0d", $urandom_range(0, 255))};
                else if (r == 9)
                    s = {s, $sformatf("%0d", $urandom_range(256, 999))};
                else if (r == 10)
                    s = {s, $sformatf("0%0d", $urandom_range(0, 99))};
            end
        end
        else if (kind < 8)
        begin
            // colon hex
            groups = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 8;
            for (int g = 0; g < groups; g++)
            begin
                r = $urandom_range(0, 15);
                n = (r < 14) ? $urandom_range(1, 4) : ((r == 14) ? 0 : $urandom_range(5, 6));
                if (g != 0)
                    s = {s, ":"};
                for (int d = 0; d < n; d++)
                begin
                    pos = $urandom_range(0, 21);
                    s = {s, hex_chars.substr(pos, pos)};
                end
            end
        end
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);

        // noise strings
        if (kind >= 8)
        begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
            begin
                r = $urandom_range(0, 4);
                case (r)
                    0: t.push_back(8'($urandom_range(0, 255)));
                    1: t.push_back(CHAR_DOT);
                    2: t.push_back(CHAR_COLON);
                    3: t.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                    default: t.push_back(hex_chars[$urandom_range(0, 21)]);
                endcase
            end
        end

        // occasional damage to the string
        if (t.size() != 0 && $urandom_range(0, 4) == 0)
        begin
            pos = $urandom_range(0, t.size() - 1);
            r = $urandom_range(0, 4);
            case (r)
                0: t[pos] = 8'($urandom_range(0, 255));
                1: t[pos] = (t[pos] == CHAR_DOT) ? CHAR_COLON : CHAR_DOT;
                2: t.push_back((kind < 4) ? CHAR_DOT : CHAR_COLON);
                3: t.insert(pos, 8'(CHAR_ZERO + $urandom_range(0, 9)));
                default: if (t.size() > 1) t.delete(pos);
            endcase
        end
        if (t.size() == 0)
            t.push_back(8'($urandom_range(0, 255)));
    endtask

    // dotted decimal rules
    task automatic test_dotted_rules();
        send_string("255.0.10.199");
        send_string("256.1.1.1");
        send_string("01.1.1.1");
        send_string("1..1.1");
        send_string("1.1.1.1.");
        send_string("1.1.1.1.1");
        send_string("1000.1.1.1");
    endtask

    // colon hex rules
    task automatic test_hex_rules();
        send_string("ffff:FFFF:0:a:A:9:1:f");
        send_string("1:2:3:4:5:6:7:8:9");
        send_string("12345:1:1:1:1:1:1:1");
        send_string("1::2:3:4:5:6:7");
        send_string("g:1:1:1:1:1:1:1");
    endtask

    // single bytes, bytes outside the digit sets, mixed separators
    task automatic test_odd_bytes();
        send_string("7");
        send_string(":");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        send_string("1.2.3.");
        send_char(8'h80, 1'b1);
        send_string("1:2.3.4");
        send_string("1.2:3:4:5:6:7:8");
    endtask

    // receiver holds off while the sender keeps offering strings
    task automatic test_output_stall();
        text_t t;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            make_address(t);
            send_text(t);
        end
        wait_for_verdicts();
    endtask

    // random strings with idling on both sides
    task automatic test_random_mix(input int char_budget);
        text_t t;
        int    start;
        start = chars_sent;
        while (chars_sent - start < char_budget)
        begin
            make_address(t);
            send_text(t);
            if ($urandom_range(0, 15) == 0)
                wait_for_verdicts();
        end
    endtask

    // back to back strings with no idling
    task automatic test_steady_stream(input int char_budget);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_mix(char_budget);
    endtask

    // receiver: random stall bursts, one long hold on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                for (int i = 1; i < LONG_HOLD; i++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // verdict checker
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                log_failure($sformatf("verdict %0d with no string pending", verdict));
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (verdict !== want)
                    log_failure($sformatf("verdict expected %0d actual %0d", want, verdict));
            end
        end
    end

    // watchdog on cycles with no request moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // test sequence
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        char_code    = '0;
        last_char    = 1'b0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_req     = 1'b0;
        fail_count   = 0;
        chars_sent   = 0;
        clear_scan();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_dotted_rules();
        test_hex_rules();
        test_odd_bytes();
        wait_for_verdicts();
        test_output_stall();
        test_random_mix(RANDOM_CHARS - 150);
        test_steady_stream(150);

        wait_for_verdicts();
        repeat (4) @(negedge clk);
        if (expected_verdicts.size() != 0)
            log_failure($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
